/* src/sorted_edge_dedup_merge_unit_assert.svh */
// assertion macros for the sorted edge dedup merge unit checker
// expects signals named clk and arst_n in the scope where a macro is used
`ifndef SORTED_EDGE_DEDUP_MERGE_UNIT_ASSERT_SVH
`define SORTED_EDGE_DEDUP_MERGE_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SEDM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sedm assertion failed");

// consequent checked in the cycle after the antecedent
`define SEDM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sedm assertion failed");

`endif

/* src/sedm_pkg.sv */
// shared types, field positions and merge functions of the edge dedup merge unit
// no dependencies
package sedm_pkg;

	// weight word layout
	localparam int CNT_LSB      = 16;
	localparam int CNT_W        = 16;
	localparam int REV_BIT      = 15;
	localparam int SRC_CONT_BIT = 14;
	localparam int DST_CONT_BIT = 13;
	localparam int DOVE_BIT     = 12;
	localparam int TRIM_W       = 12;

	// output queue geometry (depth is a power of two, pointers wrap)
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// one emitted edge
	typedef struct packed {
		logic [31:0] source;
		logic [31:0] dest;
		logic [31:0] word;
		logic        last;
	} result_t;

	// sum counts and derive contained and dovetail flags
	function automatic logic [31:0] merge_sum(input logic [31:0] oldw, input logic [31:0] neww);
		logic [CNT_W-1:0] c1;
		logic [CNT_W-1:0] c2;
		logic [CNT_W-1:0] sum;
		logic d1, d2, s1, t1, s2, t2, none1, none2, n1, n2, sc, dc, dv;
		c1    = neww[CNT_LSB +: CNT_W];
		c2    = oldw[CNT_LSB +: CNT_W];
		sum   = c1 + c2;
		d1    = neww[DOVE_BIT];
		d2    = oldw[DOVE_BIT];
		s1    = neww[SRC_CONT_BIT];
		t1    = neww[DST_CONT_BIT];
		s2    = oldw[SRC_CONT_BIT];
		t2    = oldw[DST_CONT_BIT];
		none1 = ~(s1 | t1);
		none2 = ~(s2 | t2);
		n1    = (d1 & none1) | (d2 & ~none1 & none2);
		n2    = (d2 & none2) | (n1 & ~none2 & none1);
		sc    = s1 & s2;
		dc    = t1 & t2;
		if (!(sc | dc)) begin
			dv = (c1 > c2) ? n1 : n2;
		end else begin
			dv = n1 | n2;
		end
		return {sum, 1'b0, sc, dc, dv, {TRIM_W{1'b0}}};
	endfunction

	// take the new word, keep contained flags of both
	function automatic logic [31:0] merge_replace(input logic [31:0] oldw, input logic [31:0] neww);
		logic s1, t1, dv;
		s1 = neww[SRC_CONT_BIT];
		t1 = neww[DST_CONT_BIT];
		dv = neww[DOVE_BIT] & ~s1 & ~t1;
		return {neww[31:REV_BIT], s1 | oldw[SRC_CONT_BIT], t1 | oldw[DST_CONT_BIT], dv,
			neww[TRIM_W-1:0]};
	endfunction

endpackage

/* src/sedm_ifs.sv */
// valid/ready channel interfaces for input edges and emitted edges
// no dependencies
interface sedm_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] edge_source;
	logic [31:0] edge_dest;
	logic [31:0] edge_word;
	logic        stream_end;

	modport source (output valid, edge_source, edge_dest, edge_word, stream_end, input ready);
	modport sink (input valid, edge_source, edge_dest, edge_word, stream_end, output ready);
endinterface

interface sedm_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_source;
	logic [31:0] out_dest;
	logic [31:0] out_word;
	logic        out_last;

	modport source (output valid, out_source, out_dest, out_word, out_last, input ready);
	modport sink (input valid, out_source, out_dest, out_word, out_last, output ready);
endinterface

/* src/sorted_edge_dedup_merge_unit.sv */
// sorted edge dedup merge unit: folds runs of equal (source, dest) edges into one
// depends on sedm_pkg and the channel interfaces in sedm_ifs.sv
//
//  channel    dir  handshake     payload
//  edge_in    in   valid/ready   edge_source, edge_dest, edge_word, stream_end
//  edge_out   out  valid/ready   out_source, out_dest, out_word, out_last
//  cfg        in   cfg_we        cfg_wdata (merge_mode)
//
// one item is taken per cycle while edge_in is ready; the key compare and word
// merge sit between the pending edge register and a four-entry output queue, so
// a result appears in the cycle after the item that causes it. an item may push
// up to two results. edge_in is ready while the queue has two free entries; with
// edge_out always ready, items that cause one result flow every cycle, and a key
// change with stream_end adds an extra entry, so the input stalls at three queued.
// arst_n clears the pending slot, the queue and merge_mode.
module sorted_edge_dedup_merge_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_wdata,
	sedm_in_if.sink         edge_in,
	sedm_out_if.source      edge_out
);
	import sedm_pkg::*;

	logic                merge_mode_q;
	logic                pend_valid_q;
	logic [31:0]         pend_src_q;
	logic [31:0]         pend_dst_q;
	logic [31:0]         pend_word_q;

	result_t             q_mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	logic                acc;
	logic                hit;
	logic                emit_old;
	logic                flush;
	logic                pop;
	logic [31:0]         nxt_word;
	logic [QPTR_W-1:0]   flush_ptr;
	logic [QCNT_W-1:0]   push_n;
	result_t             old_res;
	result_t             flush_res;
	result_t             head;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_mode_q <= 1'b0;
		end else if (cfg_we) begin
			merge_mode_q <= cfg_wdata;
		end
	end

	// key compare and word merge
	assign acc      = edge_in.valid && edge_in.ready;
	assign hit      = pend_valid_q && (pend_src_q == edge_in.edge_source)
	                  && (pend_dst_q == edge_in.edge_dest);
	assign emit_old = acc && pend_valid_q && !hit;
	assign flush    = acc && edge_in.stream_end;

	always_comb begin
		if (hit) begin
			nxt_word = merge_mode_q ? merge_sum(pend_word_q, edge_in.edge_word)
			                        : merge_replace(pend_word_q, edge_in.edge_word);
		end else begin
			nxt_word = edge_in.edge_word;
		end
	end

	assign old_res   = '{source: pend_src_q, dest: pend_dst_q, word: pend_word_q, last: 1'b0};
	assign flush_res = '{source: edge_in.edge_source, dest: edge_in.edge_dest,
	                     word: nxt_word, last: 1'b1};

	// pending edge control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (acc) begin
			pend_valid_q <= !edge_in.stream_end;
		end
	end

	// pending edge payload
	always_ff @(posedge clk) begin
		if (acc) begin
			pend_src_q  <= edge_in.edge_source;
			pend_dst_q  <= edge_in.edge_dest;
			pend_word_q <= nxt_word;
		end
	end

	// output queue pointers and fill count
	assign pop       = edge_out.valid && edge_out.ready;
	assign push_n    = QCNT_W'(emit_old) + QCNT_W'(flush);
	assign flush_ptr = emit_old ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + push_n - QCNT_W'(pop);
		end
	end

	// output queue storage
	always_ff @(posedge clk) begin
		if (emit_old) begin
			q_mem_q[wr_ptr_q] <= old_res;
		end
		if (flush) begin
			q_mem_q[flush_ptr] <= flush_res;
		end
	end

	// channel outputs
	assign edge_in.ready       = (cnt_q <= QCNT_W'(QDEPTH - 2));
	assign head                = q_mem_q[rd_ptr_q];
	assign edge_out.valid      = (cnt_q != '0);
	assign edge_out.out_source = head.source;
	assign edge_out.out_dest   = head.dest;
	assign edge_out.out_word   = head.word;
	assign edge_out.out_last   = head.last;

endmodule

/* src/sedm_checker.sv */
// port-level checker for the sorted edge dedup merge unit, bound into the unit module
// depends on sorted_edge_dedup_merge_unit_assert.svh
`include "sorted_edge_dedup_merge_unit_assert.svh"

module sedm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_stream_end,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_source,
	input logic [31:0] out_dest,
	input logic [31:0] out_word,
	input logic        out_last
);

	// a stalled result holds
	`SEDM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`SEDM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
		$stable({out_source, out_dest, out_word, out_last}))

	// stream end always produces a flushed edge next cycle
	`SEDM_ASSERT_NEXT(a_end_flush, in_valid && in_ready && in_stream_end, out_valid)

	// no result appears without an item
	`SEDM_ASSERT_NEXT(a_no_spurious, !out_valid && !(in_valid && in_ready), !out_valid)

	// an empty queue never blocks the input
	`SEDM_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

endmodule

bind sorted_edge_dedup_merge_unit sedm_checker u_sedm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (edge_in.valid),
	.in_ready      (edge_in.ready),
	.in_stream_end (edge_in.stream_end),
	.out_valid     (edge_out.valid),
	.out_ready     (edge_out.ready),
	.out_source    (edge_out.out_source),
	.out_dest      (edge_out.out_dest),
	.out_word      (edge_out.out_word),
	.out_last      (edge_out.out_last)
);

/* dv/tb.sv */
// self-checking testbench for the sorted edge dedup merge unit
// holds its own edge folding predictor; uses sedm_pkg and the channel interfaces
// a directed table runs first, then random streams under both merge modes
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sedm_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int unsigned RANDOM_ITEMS = 1100;
	localparam int unsigned DRAIN_CYCLES = 4;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int          DIR_ROWS     = 23;

	typedef struct packed {
		logic [31:0] source;
		logic [31:0] dest;
		logic [31:0] word;
		logic        last;
	} edge_item_t;

	typedef enum logic {ROW_EDGE, ROW_SET_MODE} row_kind_t;

	// one directed step: an edge, or a merge mode write between streams
	typedef struct packed {
		row_kind_t  kind;
		logic       mode;
		edge_item_t item;
		logic       typed;
		result_t    want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	sedm_in_if  edge_in_if ();
	sedm_out_if edge_out_if ();

	sorted_edge_dedup_merge_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.edge_in  (edge_in_if),
		.edge_out (edge_out_if)
	);

	// predictor state
	logic        fold_sum_mode;
	logic        held_valid;
	logic [31:0] held_source;
	logic [31:0] held_dest;
	logic [31:0] held_word;
	result_t     expected_edges [$];

	int unsigned fail_count;
	int unsigned cycle_count;
	bit          hold_req;

	// fixed-result rows are single edges that flush at once
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_EDGE, 1'b0, '{32'h0, 32'h0, 32'h0, 1'b1}, 1'b1,
			'{32'h0, 32'h0, 32'h0, 1'b1}},
		'{ROW_EDGE, 1'b0, '{32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1}, 1'b1,
			'{32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1}},
		'{ROW_EDGE, 1'b0, '{32'h5, 32'h7, 32'h00039abc, 1'b0}, 1'b0, '0},
		'{ROW_EDGE, 1'b0, '{32'h5, 32'h7, 32'h00024123, 1'b0}, 1'b0, '0},
		'{ROW_EDGE, 1'b0, '{32'h5, 32'h7, 32'h00011fff, 1'b0}, 1'b0, '0},
		'{ROW_EDGE, 1'b0, '{32'h5, 32'h8, 32'h00043005, 1'b0}, 1'b0, '0},
		'{ROW_EDGE, 1'b0, '{32'h6, 32'h8, 32'h00000000, 1'b0}, 1'b0, '0},
		'{ROW_EDGE, 1'b0, '{32'h6, 32'h8, 32'hffffffff, 1'b1}, 1'b0, '0},
		'{ROW_EDGE, 1'b0, '{32'h9, 32'h9, 32'h12345678, 1'b0}, 1'b0, '0},
		'{ROW_EDGE, 1'b0, '{32'ha, 32'ha, 32'h87654321, 1'b1}, 1'b0, '0},
		'{ROW_SET_MODE, 1'b1, '0, 1'b0, '0},
		'{ROW_EDGE, 1'b1, '{32'h1, 32'h2, 32'hffff1000, 1'b0}, 1'b0, '0},
		'{ROW_EDGE, 1'b1, '{32'h1, 32'h2, 32'h00010000, 1'b0}, 1'b0, '0},
		'{ROW_EDGE, 1'b1, '{32'h1, 32'h2, 32'h00104000, 1'b0}, 1'b0, '0},
		'{ROW_EDGE, 1'b1, '{32'h1, 32'h2, 32'h00206fff, 1'b1}, 1'b0, '0},
		'{ROW_EDGE, 1'b1, '{32'h3, 32'h4, 32'h00051000, 1'b0}, 1'b0, '0},
		'{ROW_EDGE, 1'b1, '{32'h3, 32'h4, 32'h00030000, 1'b0}, 1'b0, '0},
		'{ROW_EDGE, 1'b1, '{32'h3, 32'h4, 32'h00093000, 1'b0}, 1'b0, '0},
		'{ROW_EDGE, 1'b1, '{32'h3, 32'h5, 32'h00025000, 1'b0}, 1'b0, '0},
		'{ROW_EDGE, 1'b1, '{32'h3, 32'h5, 32'h0001d000, 1'b1}, 1'b0, '0},
		'{ROW_EDGE, 1'b1, '{32'h0, 32'h0, 32'hffffffff, 1'b1}, 1'b1,
			'{32'h0, 32'h0, 32'hffffffff, 1'b1}},
		'{ROW_EDGE, 1'b1, '{32'hffffffff, 32'h0, 32'h00000001, 1'b1}, 1'b1,
			'{32'hffffffff, 32'h0, 32'h00000001, 1'b1}},
		'{ROW_SET_MODE, 1'b0, '0, 1'b0, '0}
	};

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// merge mode 1: counts add, contained flags and, dovetail derived
	function automatic logic [31:0] summed_word(input logic [31:0] held, input logic [31:0] incoming);
		logic [CNT_W-1:0] cnt_new;
		logic [CNT_W-1:0] cnt_old;
		logic free_new, free_old, dove_new, dove_old, src_both, dst_both, dove;
		logic [31:0] merged;
		cnt_new  = incoming[CNT_LSB +: CNT_W];
		cnt_old  = held[CNT_LSB +: CNT_W];
		free_new = !(incoming[SRC_CONT_BIT] || incoming[DST_CONT_BIT]);
		free_old = !(held[SRC_CONT_BIT] || held[DST_CONT_BIT]);
		dove_new = free_new ? incoming[DOVE_BIT] : (free_old & held[DOVE_BIT]);
		dove_old = free_old ? held[DOVE_BIT] : (free_new & dove_new);
		src_both = incoming[SRC_CONT_BIT] & held[SRC_CONT_BIT];
		dst_both = incoming[DST_CONT_BIT] & held[DST_CONT_BIT];
		if (src_both || dst_both) begin
			dove = dove_new | dove_old;
		end else begin
			dove = (cnt_new > cnt_old) ? dove_new : dove_old;
		end
		merged = '0;
		merged[CNT_LSB +: CNT_W] = cnt_new + cnt_old;
		merged[SRC_CONT_BIT]     = src_both;
		merged[DST_CONT_BIT]     = dst_both;
		merged[DOVE_BIT]         = dove;
		return merged;
	endfunction

	// merge mode 0: new word wins, contained flags accumulate
	function automatic logic [31:0] replaced_word(input logic [31:0] held, input logic [31:0] incoming);
		logic [31:0] merged;
		merged = incoming;
		merged[SRC_CONT_BIT] = incoming[SRC_CONT_BIT] | held[SRC_CONT_BIT];
		merged[DST_CONT_BIT] = incoming[DST_CONT_BIT] | held[DST_CONT_BIT];
		merged[DOVE_BIT]     = incoming[DOVE_BIT] & ~incoming[SRC_CONT_BIT]
			& ~incoming[DST_CONT_BIT];
		return merged;
	endfunction

	// fold one accepted edge into the held edge, queue what it emits
	task automatic fold_edge(input edge_item_t it);
		result_t emitted;
		if (held_valid && held_source == it.source && held_dest == it.dest) begin
			held_word = fold_sum_mode ? summed_word(held_word, it.word)
				: replaced_word(held_word, it.word);
		end else begin
			if (held_valid) begin
				emitted = '{held_source, held_dest, held_word, 1'b0};
				expected_edges.push_back(emitted);
			end
			held_valid  = 1'b1;
			held_source = it.source;
			held_dest   = it.dest;
			held_word   = it.word;
		end
		if (it.last) begin
			emitted = '{held_source, held_dest, held_word, 1'b1};
			expected_edges.push_back(emitted);
			held_valid  = 1'b0;
			held_source = '0;
			held_dest   = '0;
			held_word   = '0;
		end
	endtask

	// sender gap: mostly none, some short, a few long
	function automatic int unsigned pick_gap(input bit burst);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (burst || r < 70) begin
			return 0;
		end else if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// offer one item after a gap, predict once it is taken
	task automatic offer_edge(input edge_item_t it, input int unsigned gap);
		if (gap > 0) begin
			edge_in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		edge_in_if.valid       <= 1'b1;
		edge_in_if.edge_source <= it.source;
		edge_in_if.edge_dest   <= it.dest;
		edge_in_if.edge_word   <= it.word;
		edge_in_if.stream_end  <= it.last;
		@(posedge clk);
		while (!edge_in_if.ready) @(posedge clk);
		fold_edge(it);
	endtask

	// merge mode write, only once every emitted edge is back
	task automatic write_mode(input logic mode);
		edge_in_if.valid <= 1'b0;
		while (expected_edges.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we        <= 1'b0;
		fold_sum_mode = mode;
	endtask

	// identifiers: small pool, full range, or corner values
	function automatic logic [31:0] random_id();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return $urandom_range(0, 15);
		end else if (r < 85) begin
			return $urandom;
		end else if (r < 93) begin
			return 32'h0;
		end
		return 32'hffffffff;
	endfunction

	// one stream: runs of equal keys, ends with stream_end, sometimes early
	task automatic send_stream(inout int unsigned sent);
		edge_item_t  it;
		int unsigned len;
		int unsigned run_left;
		int unsigned r;
		bit          burst;
		burst    = ($urandom_range(0, 3) == 0);
		len      = $urandom_range(1, 24);
		run_left = 0;
		it.source = random_id();
		it.dest   = random_id();
		for (int unsigned i = 0; i < len; i++) begin
			if (run_left == 0) begin
				r = $urandom_range(0, 99);
				if (i == 0 || r >= 60) begin
					it.source = random_id();
					it.dest   = random_id();
				end else if (r < 40) begin
					it.dest = it.dest + 1;
				end else begin
					it.source = it.source + 1;
					it.dest   = random_id();
				end
				run_left = $urandom_range(1, 4);
			end
			run_left--;
			it.word = $urandom;
			it.last = (i == len - 1) || ($urandom_range(0, 49) == 0);
			offer_edge(it, pick_gap(burst));
			sent++;
			if (it.last) begin
				break;
			end
		end
	endtask

	// input drive, reset and the stimulus sequence
	initial begin : stimulus
		int unsigned sent;
		int unsigned phase;
		logic        mode;
		edge_in_if.valid       <= 1'b0;
		edge_in_if.edge_source <= '0;
		edge_in_if.edge_dest   <= '0;
		edge_in_if.edge_word   <= '0;
		edge_in_if.stream_end  <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_wdata              <= 1'b0;
		arst_n                 <= 1'b0;
		fold_sum_mode = 1'b0;
		held_valid    = 1'b0;
		held_source   = '0;
		held_dest     = '0;
		held_word     = '0;
		hold_req      = 1'b0;
		sent          = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_SET_MODE) begin
				write_mode(dir_rows[i].mode);
			end else begin
				offer_edge(dir_rows[i].item, pick_gap(1'b0));
				if (dir_rows[i].typed) begin
					void'(expected_edges.pop_back());
					expected_edges.push_back(dir_rows[i].want);
				end
			end
		end

		// random phases, each under one merge mode
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			if (phase == 0) begin
				mode = 1'b1;
			end else if (phase == 1) begin
				mode = 1'b0;
			end else begin
				mode = $urandom_range(0, 1);
			end
			write_mode(mode);
			if (phase == 2) begin
				hold_req = 1'b1;
			end
			repeat ($urandom_range(3, 8)) send_stream(sent);
			phase++;
		end

		// drain and report
		edge_in_if.valid <= 1'b0;
		while (expected_edges.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES + 4) @(posedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// receiver ready pattern, with one long hold-off when asked
	initial begin : receiver
		int unsigned r;
		int unsigned len;
		edge_out_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				edge_out_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			r = $urandom_range(0, 99);
			if (r < 60) begin
				edge_out_if.ready <= 1'b1;
				len = $urandom_range(1, 20);
			end else if (r < 92) begin
				edge_out_if.ready <= 1'b0;
				len = $urandom_range(1, 3);
			end else begin
				edge_out_if.ready <= 1'b0;
				len = $urandom_range(10, 40);
			end
			repeat (len) @(posedge clk);
		end
	end

	// compare each emitted edge against the oldest expected one
	always @(posedge clk) begin : emit_check
		result_t want;
		if (arst_n && edge_out_if.valid && edge_out_if.ready) begin
			if (expected_edges.size() == 0) begin
				$error("unexpected emitted edge: source %h dest %h word %h last %b",
					edge_out_if.out_source, edge_out_if.out_dest, edge_out_if.out_word,
					edge_out_if.out_last);
				fail_count++;
			end else begin
				want = expected_edges.pop_front();
				if (edge_out_if.out_source !== want.source) begin
					$error("out_source: expected %h, actual %h", want.source,
						edge_out_if.out_source);
					fail_count++;
				end
				if (edge_out_if.out_dest !== want.dest) begin
					$error("out_dest: expected %h, actual %h", want.dest, edge_out_if.out_dest);
					fail_count++;
				end
				if (edge_out_if.out_word !== want.word) begin
					$error("out_word: expected %h, actual %h", want.word, edge_out_if.out_word);
					fail_count++;
				end
				if (edge_out_if.out_last !== want.last) begin
					$error("out_last: expected %b, actual %b", want.last, edge_out_if.out_last);
					fail_count++;
				end
			end
		end
	end

	// run limit
	initial fail_count = 0;
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule

/* filelist.f */
+incdir+src
src/sedm_pkg.sv
src/sedm_ifs.sv
src/sorted_edge_dedup_merge_unit.sv
src/sedm_checker.sv
dv/tb.sv
